// File: src/pmta_pkg.sv
// ----------------------------------------------------------------------------
// pmta_pkg - page map table allocator shared types and codes
// Request/response payload structs, request and status codes, field widths.
// ----------------------------------------------------------------------------
package pmta_pkg;

  localparam int PAGE_W = 10;
  localparam int CNT_W  = 11;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FWD   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REV   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INVAL = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOMAP = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SKIP  = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PAGE_W-1:0] logical_page;
    logic [PAGE_W-1:0] physical_page;
    logic              batch_last;
  } pmta_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] page_out;
    logic              found;
    logic [CNT_W-1:0]  mapped_in_batch;
    logic [CNT_W-1:0]  allocated_count;
    logic              full_flag;
  } pmta_rsp_t;

endpackage

// File: src/page_map_table_allocator.sv
// ----------------------------------------------------------------------------
// page_map_table_allocator - logical/physical page map with round-robin alloc
// Requests enter on in_valid/in_ready (in_data), one response per request
// leaves on out_valid/out_ready (out_data). cfg_wr_en/cfg_wr_data set the
// managed page count; write it only while the block is idle.
// After reset the block sweeps all MAP_PAGES entries of both map memories to
// unmapped, one entry per cycle; in_ready stays low during the sweep.
// One request at a time: in_ready is high only while idle, and the next
// request can be accepted the cycle after a response loads. A rejected or
// skipped request goes from ISSUE to RESP; a lookup, an invalidate or an
// allocate that finds the map full passes ISSUE, EVAL and RESP; a set adds SET2.
// An allocate that scans passes ISSUE, EVAL and SCAN before RESP: the scan
// probes one entry a cycle through the reverse-map read port, up to the
// managed page count, until it finds a free physical page.
// The response sits in an output register; the next request is accepted
// while it waits, and a new response waits for out_ready before it loads.
// ----------------------------------------------------------------------------
module page_map_table_allocator #(
  parameter int MAP_PAGES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pmta_pkg::pmta_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pmta_pkg::pmta_rsp_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [pmta_pkg::CNT_W-1:0] cfg_wr_data
);
  import pmta_pkg::*;

  localparam int PW   = $clog2(MAP_PAGES);
  localparam int SZ_W = (PW + 1 > CNT_W) ? PW + 1 : CNT_W;
  localparam logic [SZ_W-1:0]  MAP_PAGES_SZ = SZ_W'(MAP_PAGES);
  localparam logic [CNT_W-1:0] CFG_RST = CNT_W'((MAP_PAGES > 2047) ? 2047 : MAP_PAGES);
  localparam logic [PW-1:0]    CLR_LAST = PW'(MAP_PAGES - 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_SET2  = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] page;
  } ent_t;

  ent_t fwd_mem [MAP_PAGES];
  ent_t rev_mem [MAP_PAGES];
  ent_t fwd_q_r, rev_q_r;

  logic          fwd_we, rev_we;
  logic [PW-1:0] fwd_wa, fwd_ra, rev_wa, rev_ra;
  ent_t          fwd_wd, rev_wd;

  logic [2:0]        state_r, state_nxt;
  logic [PW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]  pages_in_use_r, pages_in_use_nxt;
  logic [PW-1:0]     alloc_ptr_r, alloc_ptr_nxt;
  logic [CNT_W-1:0]  mapped_total_r, mapped_total_nxt;
  logic [CNT_W-1:0]  batch_mapped_r, batch_mapped_nxt;
  logic              batch_stopped_r, batch_stopped_nxt;
  logic              full_seen_r, full_seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              chk_vld_r, chk_vld_nxt;

  pmta_req_t         req_r, req_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [PW-1:0]     res_page_r, res_page_nxt;
  logic              res_found_r, res_found_nxt;
  logic [PW-1:0]     rd_p_r, rd_p_nxt;
  logic [PW-1:0]     chk_p_r, chk_p_nxt;
  logic [SZ_W-1:0]   issued_r, issued_nxt;
  pmta_rsp_t         out_data_r;
  logic              out_load;

  logic [SZ_W-1:0]   cfg_ext, size;
  logic [PW-1:0]     lp_idx, pp_idx, scan_start, rd_p_wrap;
  logic              lp_ok, pp_ok, hit;
  logic [CNT_W-1:0]  total_dec, total_inc, batch_inc, total_drop;

  assign cfg_ext = SZ_W'(pages_in_use_r);
  assign size    = (pages_in_use_r == '0) ? SZ_W'(1) :
                   ((cfg_ext > MAP_PAGES_SZ) ? MAP_PAGES_SZ : cfg_ext);

  assign lp_idx = PW'(req_r.logical_page);
  assign pp_idx = PW'(req_r.physical_page);
  assign lp_ok  = SZ_W'(req_r.logical_page) < size;
  assign pp_ok  = SZ_W'(req_r.physical_page) < size;

  assign scan_start = (SZ_W'(alloc_ptr_r) < size) ? alloc_ptr_r : '0;
  assign rd_p_wrap  = (SZ_W'(rd_p_r) + SZ_W'(1) < size) ? rd_p_r + PW'(1) : '0;
  assign hit        = chk_vld_r && !rev_q_r.valid;

  assign total_dec  = (mapped_total_r == '0) ? mapped_total_r : mapped_total_r - CNT_W'(1);
  assign total_inc  = (mapped_total_r == CNT_MAX) ? mapped_total_r
                                                  : mapped_total_r + CNT_W'(1);
  assign batch_inc  = (batch_mapped_r == CNT_MAX) ? batch_mapped_r
                                                  : batch_mapped_r + CNT_W'(1);
  assign total_drop = fwd_q_r.valid ? total_dec : mapped_total_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // map memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    fwd_q_r <= fwd_mem[fwd_ra];
  end

  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[rev_wa] <= rev_wd;
    end
    rev_q_r <= rev_mem[rev_ra];
  end

  always_comb begin
    state_nxt         = state_r;
    clr_idx_nxt       = clr_idx_r;
    pages_in_use_nxt  = pages_in_use_r;
    alloc_ptr_nxt     = alloc_ptr_r;
    mapped_total_nxt  = mapped_total_r;
    batch_mapped_nxt  = batch_mapped_r;
    batch_stopped_nxt = batch_stopped_r;
    full_seen_nxt     = full_seen_r;
    chk_vld_nxt       = chk_vld_r;
    req_nxt           = req_r;
    res_status_nxt    = res_status_r;
    res_page_nxt      = res_page_r;
    res_found_nxt     = res_found_r;
    rd_p_nxt          = rd_p_r;
    chk_p_nxt         = chk_p_r;
    issued_nxt        = issued_r;
    out_valid_nxt     = out_valid_r & ~out_ready;
    out_load          = 1'b0;
    fwd_we            = 1'b0;
    fwd_wa            = lp_idx;
    fwd_wd            = '0;
    fwd_ra            = lp_idx;
    rev_we            = 1'b0;
    rev_wa            = pp_idx;
    rev_wd            = '0;
    rev_ra            = pp_idx;

    if (cfg_wr_en) begin
      pages_in_use_nxt = cfg_wr_data;
    end

    unique case (state_r)
      ST_CLR: begin
        fwd_we      = 1'b1;
        fwd_wa      = clr_idx_r;
        rev_we      = 1'b1;
        rev_wa      = clr_idx_r;
        clr_idx_nxt = clr_idx_r + PW'(1);
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        // map reads go out this cycle; checks that need no map data finish here
        res_status_nxt = STAT_OK;
        res_page_nxt   = '0;
        res_found_nxt  = 1'b0;
        state_nxt      = ST_EVAL;
        case (req_r.req_type)
          REQ_ALLOC: begin
            if (batch_stopped_r) begin
              res_status_nxt = STAT_SKIP;
              state_nxt      = ST_RESP;
            end else if (!lp_ok) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = ST_RESP;
            end
          end
          REQ_SET: begin
            if (!lp_ok || !pp_ok) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = ST_RESP;
            end
          end
          REQ_FWD, REQ_INVAL: begin
            if (!lp_ok) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = ST_RESP;
            end
          end
          REQ_REV: begin
            if (!pp_ok) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = ST_RESP;
            end
          end
          default: begin
            res_status_nxt = STAT_RANGE;
            state_nxt      = ST_RESP;
          end
        endcase
      end
      ST_EVAL: begin
        state_nxt = ST_RESP;
        case (req_r.req_type)
          REQ_ALLOC: begin
            if (fwd_q_r.valid) begin
              fwd_we = 1'b1;
              rev_we = 1'b1;
              rev_wa = fwd_q_r.page;
            end
            mapped_total_nxt = total_drop;
            if (SZ_W'(total_drop) < size) begin
              rd_p_nxt    = scan_start;
              issued_nxt  = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = ST_SCAN;
            end else begin
              res_status_nxt    = STAT_FULL;
              full_seen_nxt     = 1'b1;
              batch_stopped_nxt = 1'b1;
            end
          end
          REQ_SET: begin
            if (rev_q_r.valid) begin
              res_status_nxt = STAT_NOMAP;
            end else begin
              if (fwd_q_r.valid) begin
                rev_we = 1'b1;
                rev_wa = fwd_q_r.page;
              end
              mapped_total_nxt = total_drop;
              fwd_we    = 1'b1;
              fwd_wd    = '{valid: 1'b1, page: pp_idx};
              state_nxt = ST_SET2;
            end
          end
          REQ_FWD: begin
            if (fwd_q_r.valid) begin
              res_page_nxt  = fwd_q_r.page;
              res_found_nxt = 1'b1;
            end else begin
              res_status_nxt = STAT_NOMAP;
            end
          end
          REQ_REV: begin
            if (rev_q_r.valid) begin
              res_page_nxt  = rev_q_r.page;
              res_found_nxt = 1'b1;
            end else begin
              res_status_nxt = STAT_NOMAP;
            end
          end
          REQ_INVAL: begin
            if (fwd_q_r.valid) begin
              fwd_we           = 1'b1;
              rev_we           = 1'b1;
              rev_wa           = fwd_q_r.page;
              mapped_total_nxt = total_dec;
              res_page_nxt     = fwd_q_r.page;
              res_found_nxt    = 1'b1;
            end else begin
              res_status_nxt = STAT_NOMAP;
            end
          end
          default: begin
            res_status_nxt = STAT_RANGE;
          end
        endcase
      end
      ST_SET2: begin
        rev_we           = 1'b1;
        rev_wd           = '{valid: 1'b1, page: lp_idx};
        mapped_total_nxt = total_inc;
        res_page_nxt     = pp_idx;
        res_found_nxt    = 1'b1;
        state_nxt        = ST_RESP;
      end
      ST_SCAN: begin
        // one probe issued per cycle, checked the cycle after
        chk_vld_nxt = 1'b0;
        if (hit) begin
          fwd_we           = 1'b1;
          fwd_wd           = '{valid: 1'b1, page: chk_p_r};
          rev_we           = 1'b1;
          rev_wa           = chk_p_r;
          rev_wd           = '{valid: 1'b1, page: lp_idx};
          alloc_ptr_nxt    = chk_p_r;
          mapped_total_nxt = total_inc;
          batch_mapped_nxt = batch_inc;
          res_page_nxt     = chk_p_r;
          res_found_nxt    = 1'b1;
          state_nxt        = ST_RESP;
        end else if (issued_r == size) begin
          res_status_nxt    = STAT_FULL;
          full_seen_nxt     = 1'b1;
          batch_stopped_nxt = 1'b1;
          state_nxt         = ST_RESP;
        end else begin
          rev_ra      = rd_p_r;
          chk_p_nxt   = rd_p_r;
          chk_vld_nxt = 1'b1;
          rd_p_nxt    = rd_p_wrap;
          issued_nxt  = issued_r + SZ_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (req_r.req_type == REQ_ALLOC && req_r.batch_last) begin
            batch_mapped_nxt  = '0;
            batch_stopped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLR;
      clr_idx_r       <= '0;
      pages_in_use_r  <= CFG_RST;
      alloc_ptr_r     <= '0;
      mapped_total_r  <= '0;
      batch_mapped_r  <= '0;
      batch_stopped_r <= 1'b0;
      full_seen_r     <= 1'b0;
      out_valid_r     <= 1'b0;
      chk_vld_r       <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_idx_r       <= clr_idx_nxt;
      pages_in_use_r  <= pages_in_use_nxt;
      alloc_ptr_r     <= alloc_ptr_nxt;
      mapped_total_r  <= mapped_total_nxt;
      batch_mapped_r  <= batch_mapped_nxt;
      batch_stopped_r <= batch_stopped_nxt;
      full_seen_r     <= full_seen_nxt;
      out_valid_r     <= out_valid_nxt;
      chk_vld_r       <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_found_r  <= res_found_nxt;
    rd_p_r       <= rd_p_nxt;
    chk_p_r      <= chk_p_nxt;
    issued_r     <= issued_nxt;
    if (out_load) begin
      out_data_r.status          <= res_status_r;
      out_data_r.page_out        <= PAGE_W'(res_page_r);
      out_data_r.found           <= res_found_r;
      out_data_r.mapped_in_batch <= batch_mapped_r;
      out_data_r.allocated_count <= mapped_total_r;
      out_data_r.full_flag       <= full_seen_r;
    end
  end

endmodule
